FILE: sv/isc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isc_pkg
// Shared widths, codes and types for the image similarity check.
// ----------------------------------------------------------------------------
package isc_pkg;

   localparam int NUM_CH     = 4;
   localparam int BLK_W      = 16;
   localparam int PIX_W      = 8;
   localparam int F2_W       = 9;
   localparam int F2SQ_W     = 17;
   localparam int CNT_W      = 21;
   localparam int SUM_W      = 37;
   localparam int SQ_W       = 53;
   localparam int COLOUR_W   = 39;
   localparam int MUL_W      = 76;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int CMP_W      = 160;
   localparam int MUL_CNT_W  = $clog2(MUL_W);
   localparam int MAX_PIXELS = 1048576;
   localparam int MAX_FACTOR = 16;

   localparam logic [2:0] RSN_MATCH  = 3'd0;
   localparam logic [2:0] RSN_EMPTY  = 3'd1;
   localparam logic [2:0] RSN_LEVEL  = 3'd2;
   localparam logic [2:0] RSN_FLAT   = 3'd3;
   localparam logic [2:0] RSN_CORR   = 3'd4;
   localparam logic [2:0] RSN_ALPHA  = 3'd5;
   localparam logic [2:0] RSN_COLOUR = 3'd6;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_BLUE  = 2'd2;
   localparam logic [1:0] CH_ALPHA = 2'd3;

   typedef struct packed {
      logic [SUM_W-1:0] sum_large;
      logic [SUM_W-1:0] sum_small;
      logic [SQ_W-1:0]  sum_large_sq;
      logic [SQ_W-1:0]  sum_small_sq;
      logic [SQ_W-1:0]  sum_cross;
      logic [SUM_W-1:0] sum_abs_error;
   } lane_sums_type;

   // Block area for a register value, with the factor clamped to 1..MAX_FACTOR.
   function automatic logic [F2_W-1:0] f2_of(input logic [4:0] factor);
      logic [4:0] f;
      f = factor;
      if (factor == 5'd0) begin
         f = 5'd1;
      end else if (factor > 5'(MAX_FACTOR)) begin
         f = 5'(MAX_FACTOR);
      end
      return F2_W'(f * f);
   endfunction

endpackage
`default_nettype wire

FILE: sv/isc_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isc_lane
// One color channel: block box sum and per-image moment accumulators.
// ----------------------------------------------------------------------------
module isc_lane
   import isc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                take,
   input  wire logic [PIX_W-1:0]    large_pix,
   input  wire logic [PIX_W-1:0]    small_pix,
   input  wire logic                block_end,
   input  wire logic                image_end,
   input  wire logic                count_ok,
   input  wire logic [F2_W-1:0]     f2,
   input  wire logic                clear,
   output lane_sums_type            sums
);

   logic [BLK_W-1:0] block_sum_ff, block_sum_in;
   logic [BLK_W:0]   raw_sum;
   logic [BLK_W-1:0] sat_sum;
   logic             close_ff, close_in;
   logic [BLK_W-1:0] s_ff;
   logic [PIX_W-1:0] b_ff;
   logic [F2_W-1:0]  f2_ff;
   lane_sums_type    sums_ff, sums_in;
   logic [BLK_W:0]   bs;
   logic [BLK_W:0]   abs_err;

   assign raw_sum = {1'b0, block_sum_ff} + (BLK_W+1)'(large_pix);
   assign sat_sum = raw_sum[BLK_W] ? {BLK_W{1'b1}} : raw_sum[BLK_W-1:0];

   always_comb begin
      block_sum_in = block_sum_ff;
      close_in     = 1'b0;
      if (take) begin
         block_sum_in = (block_end || image_end) ? '0 : sat_sum;
         close_in     = block_end && count_ok;
      end
   end

   // The block multiplies are formed from the registered close stage.
   assign bs      = (BLK_W+1)'(b_ff) * (BLK_W+1)'(f2_ff);
   assign abs_err = ({1'b0, s_ff} > bs) ? ({1'b0, s_ff} - bs) : (bs - {1'b0, s_ff});

   always_comb begin
      sums_in = sums_ff;
      if (clear) begin
         sums_in = '0;
      end else if (close_ff) begin
         sums_in.sum_large     = sums_ff.sum_large + SUM_W'(s_ff);
         sums_in.sum_small     = sums_ff.sum_small + SUM_W'(b_ff);
         sums_in.sum_large_sq  = sums_ff.sum_large_sq + SQ_W'(s_ff * s_ff);
         sums_in.sum_small_sq  = sums_ff.sum_small_sq + SQ_W'(b_ff * b_ff);
         sums_in.sum_cross     = sums_ff.sum_cross + SQ_W'((BLK_W+PIX_W)'(s_ff) *
                                                           (BLK_W+PIX_W)'(b_ff));
         sums_in.sum_abs_error = sums_ff.sum_abs_error + SUM_W'(abs_err);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_sum_ff <= '0;
         close_ff     <= 1'b0;
         sums_ff      <= '0;
      end else begin
         block_sum_ff <= block_sum_in;
         close_ff     <= close_in;
         sums_ff      <= sums_in;
      end
   end

   always_ff @(posedge clock) begin
      if (close_in) begin
         s_ff  <= sat_sum;
         b_ff  <= small_pix;
         f2_ff <= f2;
      end
   end

   assign sums = sums_ff;

endmodule
`default_nettype wire

FILE: sv/isc_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isc_mul
// Shift-and-add multiplier, one operand bit per cycle.
// ----------------------------------------------------------------------------
module isc_mul
   import isc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [MUL_W-1:0]  a,
   input  wire logic [MUL_W-1:0]  b,
   output logic                   done,
   output logic [PROD_W-1:0]      prod
);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;
   logic [PROD_W-1:0]    a_ff, a_in;
   logic [MUL_W-1:0]     b_ff, b_in;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         acc_in = '0;
         a_in   = PROD_W'(a);
         b_in   = b;
      end else if (run_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = a_ff << 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule
`default_nettype wire

FILE: sv/isc_verdict.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isc_verdict
// Merges the four lanes at image end: runs the tests in channel order.
// ----------------------------------------------------------------------------
module isc_verdict
   import isc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [CNT_W-1:0]  n,
   input  wire logic [F2_W-1:0]   f2,
   input  wire lane_sums_type     sums [NUM_CH],
   input  wire logic              rsp_stall,
   output logic                   busy,
   output logic                   clear,
   output logic                   rsp_valid,
   output logic                   match,
   output logic [2:0]             fail_reason,
   output logic [1:0]             fail_channel
);

   typedef enum logic [21:0] {
      ST_IDLE     = 22'h000001,
      ST_SETTLE   = 22'h000002,
      ST_PRE_THR  = 22'h000004,
      ST_PRE_THR2 = 22'h000008,
      ST_MUL_WAIT = 22'h000010,
      ST_CH_START = 22'h000020,
      ST_CH_X     = 22'h000040,
      ST_CH_VA    = 22'h000080,
      ST_CH_X2    = 22'h000100,
      ST_CH_VB    = 22'h000200,
      ST_CH_CLASS = 22'h000400,
      ST_CH_LEVEL = 22'h000800,
      ST_CH_P     = 22'h001000,
      ST_CH_D     = 22'h002000,
      ST_CH_DD    = 22'h004000,
      ST_CH_VV    = 22'h008000,
      ST_CH_LHS   = 22'h010000,
      ST_CH_RHS   = 22'h020000,
      ST_CH_CMP   = 22'h040000,
      ST_CH_ERR   = 22'h080000,
      ST_FINAL    = 22'h100000,
      ST_EMIT     = 22'h200000
   } state_type;

   state_type           state_ff, state_in, ret_ff, ret_in;
   logic [1:0]          ch_ff, ch_in;
   logic [2:0]          reason_ff, reason_in;
   logic [1:0]          fch_ff, fch_in;
   logic [2*CNT_W-1:0]  nn_ff, nn_in;
   logic [CNT_W+F2_W-1:0] nf_ff, nf_in;
   logic [PROD_W-1:0]   thr_a_ff, thr_a_in;
   logic [PROD_W-1:0]   x_ff, x_in;
   logic [PROD_W-1:0]   y_ff, y_in;
   logic [MUL_W-1:0]    va_ff, va_in;
   logic [MUL_W-1:0]    vb_ff, vb_in;
   logic [MUL_W-1:0]    d_ff, d_in;
   logic [CMP_W-1:0]    lhs_ff, lhs_in;
   logic [CMP_W-1:0]    rhs_ff, rhs_in;
   logic [COLOUR_W-1:0] colour_ff, colour_in;
   logic                out_valid_ff, out_valid_in;
   logic                out_match_ff, out_match_in;
   logic [2:0]          out_reason_ff, out_reason_in;
   logic [1:0]          out_ch_ff, out_ch_in;
   logic                clear_in;

   logic                mul_start;
   logic [MUL_W-1:0]    mul_a, mul_b;
   logic                mul_done;
   logic [PROD_W-1:0]   mul_prod;

   lane_sums_type       cur;
   logic [F2SQ_W-1:0]   f2sq;
   logic [SUM_W-1:0]    level_d;
   logic [CMP_W-1:0]    x_wide, y_wide;
   logic                flat_a, flat_b;

   isc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   assign cur    = sums[ch_ff];
   assign f2sq   = F2SQ_W'(f2) * F2SQ_W'(f2);
   assign flat_a = PROD_W'(va_ff) <= thr_a_ff;
   assign flat_b = PROD_W'(vb_ff) <= PROD_W'({nn_ff, 4'b0});
   assign level_d = (cur.sum_large > mul_prod[SUM_W-1:0])
                  ? (cur.sum_large - mul_prod[SUM_W-1:0])
                  : (mul_prod[SUM_W-1:0] - cur.sum_large);
   assign x_wide = CMP_W'(x_ff);
   assign y_wide = CMP_W'(y_ff);

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      ch_in         = ch_ff;
      reason_in     = reason_ff;
      fch_in        = fch_ff;
      nn_in         = nn_ff;
      nf_in         = nf_ff;
      thr_a_in      = thr_a_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      va_in         = va_ff;
      vb_in         = vb_ff;
      d_in          = d_ff;
      lhs_in        = lhs_ff;
      rhs_in        = rhs_ff;
      colour_in     = colour_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_match_in  = out_match_ff;
      out_reason_in = out_reason_ff;
      out_ch_in     = out_ch_ff;
      clear_in      = 1'b0;
      mul_start     = 1'b0;
      mul_a         = '0;
      mul_b         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            ch_in     = CH_RED;
            colour_in = '0;
            fch_in    = CH_RED;
            nf_in     = (CNT_W+F2_W)'(n) * (CNT_W+F2_W)'(f2);
            if (n == '0) begin
               reason_in = RSN_EMPTY;
               state_in  = ST_EMIT;
            end else begin
               mul_start = 1'b1;
               mul_a     = MUL_W'(n);
               mul_b     = MUL_W'(n);
               ret_in    = ST_PRE_THR;
               state_in  = ST_MUL_WAIT;
            end
         end
         ST_PRE_THR: begin
            nn_in     = mul_prod[2*CNT_W-1:0];
            mul_start = 1'b1;
            mul_a     = MUL_W'(mul_prod[2*CNT_W-1:0]);
            mul_b     = MUL_W'(f2sq);
            ret_in    = ST_PRE_THR2;
            state_in  = ST_MUL_WAIT;
         end
         ST_PRE_THR2: begin
            thr_a_in = mul_prod << 4;
            state_in = ST_CH_START;
         end
         ST_MUL_WAIT: begin
            if (mul_done) begin
               state_in = ret_ff;
            end
         end
         ST_CH_START: begin
            mul_start = 1'b1;
            mul_a     = MUL_W'(n);
            mul_b     = MUL_W'(cur.sum_large_sq);
            ret_in    = ST_CH_X;
            state_in  = ST_MUL_WAIT;
         end
         ST_CH_X: begin
            x_in      = mul_prod;
            mul_start = 1'b1;
            mul_a     = MUL_W'(cur.sum_large);
            mul_b     = MUL_W'(cur.sum_large);
            ret_in    = ST_CH_VA;
            state_in  = ST_MUL_WAIT;
         end
         ST_CH_VA: begin
            va_in     = (x_ff > mul_prod) ? MUL_W'(x_ff - mul_prod) : '0;
            mul_start = 1'b1;
            mul_a     = MUL_W'(n);
            mul_b     = MUL_W'(cur.sum_small_sq);
            ret_in    = ST_CH_X2;
            state_in  = ST_MUL_WAIT;
         end
         ST_CH_X2: begin
            x_in      = mul_prod;
            mul_start = 1'b1;
            mul_a     = MUL_W'(cur.sum_small);
            mul_b     = MUL_W'(cur.sum_small);
            ret_in    = ST_CH_VB;
            state_in  = ST_MUL_WAIT;
         end
         ST_CH_VB: begin
            vb_in    = (x_ff > mul_prod) ? MUL_W'(x_ff - mul_prod) : '0;
            state_in = ST_CH_CLASS;
         end
         ST_CH_CLASS: begin
            if (flat_a && flat_b) begin
               mul_start = 1'b1;
               mul_a     = MUL_W'(f2);
               mul_b     = MUL_W'(cur.sum_small);
               ret_in    = ST_CH_LEVEL;
               state_in  = ST_MUL_WAIT;
            end else if (flat_a || flat_b) begin
               reason_in = RSN_FLAT;
               fch_in    = ch_ff;
               state_in  = ST_EMIT;
            end else begin
               mul_start = 1'b1;
               mul_a     = MUL_W'(n);
               mul_b     = MUL_W'(cur.sum_cross);
               ret_in    = ST_CH_P;
               state_in  = ST_MUL_WAIT;
            end
         end
         ST_CH_LEVEL: begin
            if (level_d > SUM_W'({nf_ff, 3'b0})) begin
               reason_in = RSN_LEVEL;
               fch_in    = ch_ff;
               state_in  = ST_EMIT;
            end else begin
               state_in = ST_CH_ERR;
            end
         end
         ST_CH_P: begin
            x_in      = mul_prod;
            mul_start = 1'b1;
            mul_a     = MUL_W'(cur.sum_large);
            mul_b     = MUL_W'(cur.sum_small);
            ret_in    = ST_CH_D;
            state_in  = ST_MUL_WAIT;
         end
         ST_CH_D: begin
            if (x_ff <= mul_prod) begin
               reason_in = RSN_CORR;
               fch_in    = ch_ff;
               state_in  = ST_EMIT;
            end else begin
               d_in     = MUL_W'(x_ff - mul_prod);
               state_in = ST_CH_DD;
            end
         end
         ST_CH_DD: begin
            mul_start = 1'b1;
            mul_a     = d_ff;
            mul_b     = d_ff;
            ret_in    = ST_CH_VV;
            state_in  = ST_MUL_WAIT;
         end
         ST_CH_VV: begin
            x_in      = mul_prod;
            mul_start = 1'b1;
            mul_a     = va_ff;
            mul_b     = vb_ff;
            ret_in    = ST_CH_LHS;
            state_in  = ST_MUL_WAIT;
         end
         ST_CH_LHS: begin
            // 100 * D^2 as a sum of shifted copies.
            lhs_in   = (x_wide << 6) + (x_wide << 5) + (x_wide << 2);
            y_in     = mul_prod;
            state_in = ST_CH_RHS;
         end
         ST_CH_RHS: begin
            // 81 * VA * VB the same way.
            rhs_in   = (y_wide << 6) + (y_wide << 4) + y_wide;
            state_in = ST_CH_CMP;
         end
         ST_CH_CMP: begin
            if (lhs_ff < rhs_ff) begin
               reason_in = RSN_CORR;
               fch_in    = ch_ff;
               state_in  = ST_EMIT;
            end else begin
               state_in = ST_CH_ERR;
            end
         end
         ST_CH_ERR: begin
            if (ch_ff == CH_ALPHA) begin
               if (cur.sum_abs_error > SUM_W'({nf_ff, 4'b0})) begin
                  reason_in = RSN_ALPHA;
                  fch_in    = ch_ff;
                  state_in  = ST_EMIT;
               end else begin
                  state_in = ST_FINAL;
               end
            end else begin
               colour_in = colour_ff + COLOUR_W'(cur.sum_abs_error);
               ch_in     = ch_ff + 1'b1;
               state_in  = ST_CH_START;
            end
         end
         ST_FINAL: begin
            if (colour_ff > (COLOUR_W'({nf_ff, 5'b0}) + COLOUR_W'({nf_ff, 4'b0}))) begin
               reason_in = RSN_COLOUR;
            end else begin
               reason_in = RSN_MATCH;
            end
            fch_in   = CH_RED;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in  = 1'b1;
               out_match_in  = (reason_ff == RSN_MATCH);
               out_reason_in = reason_ff;
               out_ch_in     = fch_ff;
               clear_in      = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff         <= ch_in;
      reason_ff     <= reason_in;
      fch_ff        <= fch_in;
      nn_ff         <= nn_in;
      nf_ff         <= nf_in;
      thr_a_ff      <= thr_a_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      va_ff         <= va_in;
      vb_ff         <= vb_in;
      d_ff          <= d_in;
      lhs_ff        <= lhs_in;
      rhs_ff        <= rhs_in;
      colour_ff     <= colour_in;
      out_match_ff  <= out_match_in;
      out_reason_ff <= out_reason_in;
      out_ch_ff     <= out_ch_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign clear        = clear_in;
   assign rsp_valid    = out_valid_ff;
   assign match        = out_match_ff;
   assign fail_reason  = out_reason_ff;
   assign fail_channel = out_ch_ff;

endmodule
`default_nettype wire

FILE: sv/image_similarity_check_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one texel transaction per cycle while an image streams in.
// After the last texel of an image, the verdict is formed from at most 2 + 8 per
// channel products in the shared bit-serial multiplier; req_stall is high meanwhile.
// Reset (synchronous, active high) clears all sums and sets scale_factor to 1.
// ----------------------------------------------------------------------------
// image_similarity_check_core
// Streams large-image texels through four channel lanes and, at image end,
// merges the lane sums into a single match verdict.
// ----------------------------------------------------------------------------
module image_similarity_check_core
   import isc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [4:0]  csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_large_red,
   input  wire logic [7:0]  req_large_green,
   input  wire logic [7:0]  req_large_blue,
   input  wire logic [7:0]  req_large_alpha,
   input  wire logic [7:0]  req_small_red,
   input  wire logic [7:0]  req_small_green,
   input  wire logic [7:0]  req_small_blue,
   input  wire logic [7:0]  req_small_alpha,
   input  wire logic        req_block_end,
   input  wire logic        req_image_end,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_match,
   output logic [2:0]       rsp_fail_reason,
   output logic [1:0]       rsp_fail_channel
);

   logic [4:0]       scale_factor_ff, scale_factor_in;
   logic [CNT_W-1:0] pixel_count_ff, pixel_count_in;
   logic             take;
   logic             count_ok;
   logic             busy;
   logic             clear;
   logic [F2_W-1:0]  f2;
   logic [PIX_W-1:0] large_pix [NUM_CH];
   logic [PIX_W-1:0] small_pix [NUM_CH];
   lane_sums_type    sums [NUM_CH];

   // The register write transaction is always taken.
   assign csr_ready = 1'b1;

   // Texel transactions are held off only while a verdict is being worked out.
   assign req_stall = busy;
   assign take      = req_valid && !req_stall;
   assign f2        = f2_of(scale_factor_ff);
   assign count_ok  = pixel_count_ff < CNT_W'(MAX_PIXELS);

   always_comb begin
      scale_factor_in = scale_factor_ff;
      if (csr_valid && csr_ready) begin
         scale_factor_in = csr_data;
      end
   end

   // Closed blocks are counted up to the image limit; the count returns to zero
   // once the verdict has been handed to the output register.
   always_comb begin
      pixel_count_in = pixel_count_ff;
      if (clear) begin
         pixel_count_in = '0;
      end else if (take && req_block_end && count_ok) begin
         pixel_count_in = pixel_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_factor_ff <= 5'd1;
         pixel_count_ff  <= '0;
      end else begin
         scale_factor_ff <= scale_factor_in;
         pixel_count_ff  <= pixel_count_in;
      end
   end

   assign large_pix[0] = req_large_red;
   assign large_pix[1] = req_large_green;
   assign large_pix[2] = req_large_blue;
   assign large_pix[3] = req_large_alpha;
   assign small_pix[0] = req_small_red;
   assign small_pix[1] = req_small_green;
   assign small_pix[2] = req_small_blue;
   assign small_pix[3] = req_small_alpha;

   // One lane per color channel; each keeps its own box sum and moments.
   for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
      isc_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .take      (take),
         .large_pix (large_pix[c]),
         .small_pix (small_pix[c]),
         .block_end (req_block_end),
         .image_end (req_image_end),
         .count_ok  (count_ok),
         .f2        (f2),
         .clear     (clear),
         .sums      (sums[c])
      );
   end

   // The merging stage walks the channels in order and registers the verdict.
   isc_verdict u_verdict (
      .clock        (clock),
      .reset        (reset),
      .start        (take && req_image_end),
      .n            (pixel_count_ff),
      .f2           (f2),
      .sums         (sums),
      .rsp_stall    (rsp_stall),
      .busy         (busy),
      .clear        (clear),
      .rsp_valid    (rsp_valid),
      .match        (rsp_match),
      .fail_reason  (rsp_fail_reason),
      .fail_channel (rsp_fail_channel)
   );

endmodule
`default_nettype wire
